// ===== design/query_id_remap_table_unit_assert.svh =====
// Assertion macros for the ID remap table
`ifndef QUERY_ID_REMAP_TABLE_UNIT_ASSERT_SVH
`define QUERY_ID_REMAP_TABLE_UNIT_ASSERT_SVH

// same-cycle implication, masked during reset
`define QIDR_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("qidr assertion failed");

// next-cycle implication, masked during reset
`define QIDR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("qidr assertion failed");

`endif

// ===== design/qidr_pkg.sv =====
package qidr_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int ID_W        = 16;
    localparam int IP_W        = 32;
    localparam int PORT_W      = 16;
    localparam int CLI_W       = ID_W + IP_W + PORT_W;

    localparam logic CMD_QUERY  = 1'b0;
    localparam logic CMD_ANSWER = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NOT_FOUND = 2'd1,
        STATUS_FULL      = 2'd2
    } qidr_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_QSCAN,
        ST_ASCAN,
        ST_AFETCH,
        ST_DONE
    } qidr_state_t;

    // one input beat, unpacked
    typedef struct packed {
        logic              cmd;
        logic [ID_W-1:0]   cli_id;
        logic [IP_W-1:0]   cli_ip;
        logic [PORT_W-1:0] cli_port;
        logic [ID_W-1:0]   ans_id;
    } qidr_item_t;

    // one result beat
    typedef struct packed {
        qidr_status_t      status;
        logic [ID_W-1:0]   txn;
        logic [IP_W-1:0]   ip;
        logic [PORT_W-1:0] port;
    } qidr_res_t;

    // table memory control from the sequencer
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [IDX_W-1:0] id_raddr;
        logic [IDX_W-1:0] cli_raddr;
    } qidr_mem_req_t;

endpackage

// ===== design/qidr_ram.sv =====
module qidr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // single write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/qidr_ctrl.sv =====
module qidr_ctrl import qidr_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    // item side
    input  logic              in_valid,
    output logic              in_ready,
    input  qidr_item_t        in_item,
    input  logic [ID_W-1:0]   max_id,
    // result side
    output logic              res_valid,
    input  logic              res_free,
    output qidr_res_t         res,
    output logic [CNT_W-1:0]  in_use,
    // table memories
    output qidr_mem_req_t     mem_req,
    output logic [ID_W-1:0]   id_wdata,
    output logic [CLI_W-1:0]  cli_wdata,
    input  logic [ID_W-1:0]   id_rdata,
    input  logic [CLI_W-1:0]  cli_rdata
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_DEPTH);

    qidr_state_t            state_reg, state_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [IDX_W-1:0]       rd_idx_reg, rd_idx_next;
    logic                   rd_vld_reg, rd_vld_next;
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic [ID_W-1:0]        next_id_reg, next_id_next;
    logic [CNT_W-1:0]       in_use_reg, in_use_next;
    qidr_item_t             item_reg, item_next;
    qidr_res_t              res_reg, res_next;

    logic [ID_W-1:0]        assign_id;
    logic                   hit;

    // upstream ID wraps to zero past the configured maximum
    assign assign_id = (next_id_reg > max_id) ? '0 : next_id_reg;
    assign hit = rd_vld_reg && valid_reg[rd_idx_reg] && (id_rdata == item_reg.ans_id);

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            valid_reg   <= '0;
            next_id_reg <= ID_W'(1);
            in_use_reg  <= '0;
            rd_vld_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            next_id_reg <= next_id_next;
            in_use_reg  <= in_use_next;
            rd_vld_reg  <= rd_vld_next;
        end
    end

    // payload and scan index
    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        rd_idx_reg <= rd_idx_next;
        item_reg   <= item_next;
        res_reg    <= res_next;
    end

    // sequencer
    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        rd_idx_next  = idx_reg;
        rd_vld_next  = 1'b0;
        valid_next   = valid_reg;
        next_id_next = next_id_reg;
        in_use_next  = in_use_reg;
        item_next    = item_reg;
        res_next     = res_reg;
        in_ready     = 1'b0;
        res_valid    = 1'b0;
        mem_req.we        = 1'b0;
        mem_req.waddr     = idx_reg;
        mem_req.id_raddr  = idx_reg;
        mem_req.cli_raddr = rd_idx_reg;

        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    item_next = in_item;
                    idx_next  = '0;
                    if (in_item.cmd == CMD_QUERY) begin
                        if (in_use_reg == FULL_CNT) begin
                            res_next   = '{STATUS_FULL, '0, '0, '0};
                            state_next = ST_DONE;
                        end else begin
                            state_next = ST_QSCAN;
                        end
                    end else begin
                        state_next = ST_ASCAN;
                    end
                end
            end
            // lowest free slot, one valid bit a cycle
            ST_QSCAN: begin
                if (!valid_reg[idx_reg]) begin
                    mem_req.we              = 1'b1;
                    valid_next[idx_reg]     = 1'b1;
                    in_use_next             = in_use_reg + CNT_W'(1);
                    next_id_next            = assign_id + ID_W'(1);
                    res_next                = '{STATUS_OK, assign_id, '0, '0};
                    state_next              = ST_DONE;
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            // read one upstream ID a cycle, compare it in the next cycle
            ST_ASCAN: begin
                rd_vld_next = 1'b1;
                idx_next    = idx_reg + IDX_W'(1);
                if (hit) begin
                    rd_vld_next            = 1'b0;
                    valid_next[rd_idx_reg] = 1'b0;
                    in_use_next            = in_use_reg - CNT_W'(1);
                    state_next             = ST_AFETCH;
                end else if (rd_vld_reg && rd_idx_reg == LAST_IDX) begin
                    rd_vld_next = 1'b0;
                    res_next    = '{STATUS_NOT_FOUND, '0, '0, '0};
                    state_next  = ST_DONE;
                end
            end
            // client record of the matched slot is on the read port
            ST_AFETCH: begin
                res_next   = '{STATUS_OK, cli_rdata[ID_W-1:0],
                               cli_rdata[ID_W +: IP_W], cli_rdata[ID_W+IP_W +: PORT_W]};
                state_next = ST_DONE;
            end
            ST_DONE: begin
                res_valid = 1'b1;
                if (res_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign id_wdata  = assign_id;
    assign cli_wdata = {item_reg.cli_port, item_reg.cli_ip, item_reg.cli_id};
    assign res       = res_reg;
    assign in_use    = in_use_reg;

endmodule

// ===== design/query_id_remap_table_unit.sv =====
// Channel   | Handshake                 | Payload
// ----------+---------------------------+-------------------------------------------
// input     | s_tvalid / s_tready       | s_tuser: cmd; s_tdata: client fields, answer ID
// result    | m_tvalid / m_tready       | m_tuser: status; m_tdata: txn ID, IP, port
// config    | cfg_valid / cfg_ready     | cfg_data: max_upstream_id
//
// One beat at a time. A query scans for the lowest free slot; a full table gives
// STATUS_FULL without a scan. An answer scans the upstream IDs, then fetches the matching
// client record. The scan walks the table one entry a cycle over the registered ID RAM.
// aresetn (synchronous) clears the valid bits, in-use count and handshakes; IDs restart at 1.
// A finished result waits in the output register while the next beat is accepted.
`include "query_id_remap_table_unit_assert.svh"

module query_id_remap_table_unit import qidr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // input beats
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // client_txn_id, client_addr, client_port, answer_txn_id
    input  logic        s_tuser,   // cmd
    // result beats
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // result_txn_id, result_ip, result_port
    output logic [1:0]  m_tuser,   // status
    // configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    logic [ID_W-1:0]   max_id_reg;
    logic              m_tvalid_reg;
    logic [63:0]       m_tdata_reg;
    logic [1:0]        m_tuser_reg;

    qidr_item_t        item;
    qidr_res_t         res;
    logic              res_valid;
    logic              res_free;
    logic [CNT_W-1:0]  in_use;
    qidr_mem_req_t     mem_req;
    logic [ID_W-1:0]   id_wdata, id_rdata;
    logic [CLI_W-1:0]  cli_wdata, cli_rdata;

    // input unpacking
    assign item.cmd      = s_tuser;
    assign item.cli_id   = s_tdata[15:0];
    assign item.cli_ip   = s_tdata[47:16];
    assign item.cli_port = s_tdata[63:48];
    assign item.ans_id   = s_tdata[79:64];

    // configuration register
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_id_reg <= 16'hFFFF;
        end else if (cfg_valid) begin
            max_id_reg <= cfg_data;
        end
    end

    qidr_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (item),
        .max_id    (max_id_reg),
        .res_valid (res_valid),
        .res_free  (res_free),
        .res       (res),
        .in_use    (in_use),
        .mem_req   (mem_req),
        .id_wdata  (id_wdata),
        .cli_wdata (cli_wdata),
        .id_rdata  (id_rdata),
        .cli_rdata (cli_rdata)
    );

    // upstream IDs, scanned on answers
    qidr_ram #(.WIDTH(ID_W), .DEPTH(TABLE_DEPTH)) u_id_ram (
        .aclk  (aclk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (id_wdata),
        .raddr (mem_req.id_raddr),
        .rdata (id_rdata)
    );

    // client ID, address and port per slot
    qidr_ram #(.WIDTH(CLI_W), .DEPTH(TABLE_DEPTH)) u_cli_ram (
        .aclk  (aclk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (cli_wdata),
        .raddr (mem_req.cli_raddr),
        .rdata (cli_rdata)
    );

    // output register
    assign res_free = !m_tvalid_reg || m_tready;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_free) begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_free) begin
            m_tdata_reg <= {res.port, res.ip, res.txn};
            m_tuser_reg <= res.status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `QIDR_ASSERT_NOW(a_ready_not_done, aclk, aresetn, s_tready, !res_valid)
    `QIDR_ASSERT_NOW(a_full_only_when_full, aclk, aresetn,
        res_valid && res.status == STATUS_FULL, in_use == CNT_W'(TABLE_DEPTH))
    `QIDR_ASSERT_NEXT(a_result_loaded, aclk, aresetn, res_valid && res_free, m_tvalid)

endmodule
